@@ rtl/gsm_pkg.sv @@
// Package for the Gassmann saturated moduli core: item types, queue entry,
// queue status and shared constants. Depends on nothing.
package gsm_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PoreW  = 17;
  localparam int unsigned DivW   = 116;
  localparam int unsigned QDepth = 2;
  localparam logic [PoreW-1:0] PoreOne = 17'h10000;

  typedef struct packed {
    logic [WordW-1:0] dry_bulk;
    logic [WordW-1:0] dry_shear;
    logic [WordW-1:0] dry_density;
    logic [WordW-1:0] mineral_bulk;
    logic [WordW-1:0] fluid_bulk;
    logic [WordW-1:0] fluid_density;
    logic [PoreW-1:0] pore_fraction;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] sat_bulk;
    logic [WordW-1:0] sat_shear;
    logic [WordW-1:0] sat_density;
    logic             math_fault;
  } out_item_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    logic [WordW-1:0] kd;
    logic [WordW-1:0] mu;
    logic [WordW-1:0] rd;
    logic [WordW-1:0] km;
    logic [WordW-1:0] kf;
    logic [WordW-1:0] rf;
    logic [PoreW-1:0] pore;
    logic [PoreW-1:0] pore_c;
    logic             div_zero;
    logic             fault;
  } cls_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       full;
    logic       empty;
  } q_stat_t;

  // Values that ride along the back pipeline next to the arithmetic.
  typedef struct packed {
    logic [WordW-1:0] kd;
    logic [WordW-1:0] mu;
    logic [WordW-1:0] dens;
    logic             fault;
    logic             sat;
  } side_t;

endpackage

@@ rtl/gsm_front.sv @@
// Front end: takes one item, clamps porosity and flags zero divisors.
// Depends on gsm_pkg.
module gsm_front import gsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_item_t item_i,
  input  logic     q_full_i,
  output logic     push_o,
  output cls_t     cls_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;
  logic     over;
  logic [PoreW-1:0] pore;

  assign busy   = valid_q && q_full_i;
  assign accept = start && !busy;
  assign push_o = valid_q && !q_full_i;
  assign valid_d = accept || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign over = item_q.pore_fraction > PoreOne;
  assign pore = over ? PoreOne : item_q.pore_fraction;

  always_comb begin
    cls_o.kd       = item_q.dry_bulk;
    cls_o.mu       = item_q.dry_shear;
    cls_o.rd       = item_q.dry_density;
    cls_o.km       = item_q.mineral_bulk;
    cls_o.kf       = item_q.fluid_bulk;
    cls_o.rf       = item_q.fluid_density;
    cls_o.pore     = pore;
    cls_o.pore_c   = PoreOne - pore;
    cls_o.div_zero = (item_q.mineral_bulk == '0) || (item_q.fluid_bulk == '0);
    cls_o.fault    = over || cls_o.div_zero;
  end

endmodule

@@ rtl/gsm_queue.sv @@
// Two-entry queue between the front end and the arithmetic pipeline.
// Depends on gsm_pkg.
module gsm_queue import gsm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cls_t    data_i,
  input  logic    pop_i,
  output cls_t    data_o,
  output q_stat_t stat_o
);

  cls_t       mem [QDepth];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop = pop_i && (cnt_q != 2'd0);
  assign wr_d   = push_i ? ~wr_q : wr_q;
  assign rd_d   = do_pop ? ~rd_q : rd_q;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  assign data_o       = mem[rd_q];
  assign stat_o.cnt   = cnt_q;
  assign stat_o.full  = (cnt_q == 2'(QDepth));
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

@@ rtl/gsm_back.sv @@
// Arithmetic pipeline: products, Gassmann rational, 32-step restoring
// division, final add and saturation. Depends on gsm_pkg.
module gsm_back import gsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cls_t      cls_i,
  output logic      done_o,
  output out_item_t result_o
);

  // Stage 1: first-level products.
  logic        v1_q;
  side_t       s1_q;
  logic [63:0] dd1_q, kk1_q, kmf1_q, kdf1_q;
  logic [31:0] kf1_q;
  logic [16:0] p1_q, pc1_q;
  logic [48:0] da1_q, db1_q;
  logic [31:0] diff;

  assign diff = (cls_i.km >= cls_i.kd) ? cls_i.km - cls_i.kd : cls_i.kd - cls_i.km;

  always_ff @(posedge clk_i) begin
    s1_q.kd    <= cls_i.kd;
    s1_q.mu    <= cls_i.mu;
    s1_q.dens  <= '0;
    s1_q.fault <= cls_i.fault;
    s1_q.sat   <= cls_i.div_zero;
    dd1_q  <= 64'(diff) * 64'(diff);
    kk1_q  <= 64'(cls_i.km) * 64'(cls_i.km);
    kmf1_q <= 64'(cls_i.km) * 64'(cls_i.kf);
    kdf1_q <= 64'(cls_i.kd) * 64'(cls_i.kf);
    kf1_q  <= cls_i.kf;
    p1_q   <= cls_i.pore;
    pc1_q  <= cls_i.pore_c;
    da1_q  <= 49'(cls_i.pore_c) * 49'(cls_i.rd);
    db1_q  <= 49'(cls_i.pore) * 49'(cls_i.rf);
  end

  // Stage 2: wide products split in 32-bit halves; density rounding.
  logic        v2_q;
  side_t       s2_q, s2_d;
  logic [63:0] ddk_lo_q, ddk_hi_q, kdf2_q;
  logic [48:0] kkp_lo_q, kkp_hi_q, kmp_lo_q, kmp_hi_q;
  logic [49:0] dsum;

  assign dsum = 50'(da1_q) + 50'(db1_q) + 50'd32768;

  always_comb begin
    s2_d      = s1_q;
    s2_d.dens = dsum[47:16];
  end

  always_ff @(posedge clk_i) begin
    s2_q      <= s2_d;
    ddk_lo_q  <= 64'(dd1_q[31:0]) * 64'(kf1_q);
    ddk_hi_q  <= 64'(dd1_q[63:32]) * 64'(kf1_q);
    kkp_lo_q  <= 49'(kk1_q[31:0]) * 49'(p1_q);
    kkp_hi_q  <= 49'(kk1_q[63:32]) * 49'(p1_q);
    kmp_lo_q  <= 49'(kmf1_q[31:0]) * 49'(pc1_q);
    kmp_hi_q  <= 49'(kmf1_q[63:32]) * 49'(pc1_q);
    kdf2_q    <= kdf1_q;
  end

  // Stage 3: numerator and denominator of the rational.
  logic         v3_q;
  side_t        s3_q;
  logic [111:0] num3_q;
  logic [83:0]  den3_q;

  always_ff @(posedge clk_i) begin
    s3_q   <= s2_q;
    num3_q <= (112'(ddk_hi_q) << 48) + (112'(ddk_lo_q) << 16);
    den3_q <= (84'(kkp_hi_q) << 32) + 84'(kkp_lo_q)
            + (84'(kmp_hi_q) << 32) + 84'(kmp_lo_q)
            + (84'(kdf2_q) << 16);
  end

  // Stage 4: round-half-up form, quotient of (2n + d) by 2d.
  logic            v4_q;
  side_t           s4_q;
  logic [DivW-1:0] nn4_q, dv4_q;

  always_ff @(posedge clk_i) begin
    s4_q  <= s3_q;
    nn4_q <= (DivW'(num3_q) << 1) + DivW'(den3_q);
    dv4_q <= DivW'(den3_q) << 1;
  end

  // Division stages: index 0 holds the overflow check, each next stage one bit.
  logic            dv_v_q   [0:32];
  side_t           dv_s_q   [0:32];
  logic [DivW-1:0] dv_rem_q [0:32];
  logic [DivW-1:0] dv_den_q [0:32];
  logic [31:0]     dv_quo_q [0:32];
  side_t           dv_s0_d;

  always_comb begin
    dv_s0_d     = s4_q;
    dv_s0_d.sat = s4_q.sat || (nn4_q >= (dv4_q << 32));
  end

  always_ff @(posedge clk_i) begin
    dv_s_q[0]     <= dv_s0_d;
    dv_rem_q[0]   <= nn4_q;
    dv_den_q[0]   <= dv4_q;
    dv_quo_q[0]   <= '0;
  end

  for (genvar k = 0; k < 32; k++) begin : g_div
    logic [DivW-1:0] sh;
    logic            ge;
    assign sh = dv_den_q[k] << (31 - k);
    assign ge = dv_rem_q[k] >= sh;

    always_ff @(posedge clk_i) begin
      dv_s_q[k+1]   <= dv_s_q[k];
      dv_den_q[k+1] <= dv_den_q[k];
      dv_rem_q[k+1] <= ge ? dv_rem_q[k] - sh : dv_rem_q[k];
      dv_quo_q[k+1] <= dv_quo_q[k] | (ge ? (32'd1 << (31 - k)) : 32'd0);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
  end

  // Final stage: add dry bulk and saturate.
  logic [32:0] bsum;
  side_t       sf;
  logic        bsat;

  assign sf   = dv_s_q[32];
  assign bsum = 33'(sf.kd) + 33'(dv_quo_q[32]);
  assign bsat = sf.sat || bsum[32];

  always_ff @(posedge clk_i) begin
    result_o.sat_bulk    <= bsat ? '1 : bsum[31:0];
    result_o.sat_shear   <= sf.mu;
    result_o.sat_density <= sf.dens;
    result_o.math_fault  <= sf.fault || bsat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      dv_v_q[0] <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      v1_q      <= valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      dv_v_q[0] <= v4_q;
      done_o    <= dv_v_q[32];
    end
  end

endmodule

@@ rtl/gassmann_saturated_moduli_core.sv @@
// Top level of the Gassmann saturated moduli core: front end, queue and
// arithmetic pipeline. Depends on gsm_pkg, gsm_front, gsm_queue, gsm_back.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------
//   item in   | start, busy          | item_i   (in_item_t)
//   result    | done_o (one strobe)  | result_o (out_item_t)
//
// One item per cycle is accepted while busy is low; each result is presented
// after its item has passed the front-end register, the queue entry, four
// product and sum stages, the overflow check, 32 divider stages and the
// output register. The receiver cannot stall, so the pipeline never halts,
// the queue never fills and busy stays low in practice. Reset clears all
// valid bits at once.
module gassmann_saturated_moduli_core import gsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o
);

  logic    push;
  cls_t    cls, q_data;
  q_stat_t q_stat;

  gsm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .cls_o    (cls)
  );

  gsm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls),
    .pop_i  (1'b1),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  gsm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!q_stat.empty),
    .cls_i    (q_data),
    .done_o   (done_o),
    .result_o (result_o)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.cnt <= 2'(QDepth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into a full queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.empty && !push |=> q_stat.cnt == $past(q_stat.cnt) - 2'd1)
    else $error("queue did not drain");

endmodule
